[rtl/dnsp_pkg.sv]
// Package for the DNS response field parser: parse phases, item kinds and the
// event record passed from the parsing front end to the output stage.
// No dependencies.
package dnsp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_QLEN   = 3'd1,
		PH_QCHAR  = 3'd2,
		PH_QFIXED = 3'd3,
		PH_AFIXED = 3'd4,
		PH_RDATA  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef enum logic [3:0] {
		KIND_ID       = 4'd0,
		KIND_FLAGS    = 4'd1,
		KIND_QDCOUNT  = 4'd2,
		KIND_ANCOUNT  = 4'd3,
		KIND_NSCOUNT  = 4'd4,
		KIND_ARCOUNT  = 4'd5,
		KIND_QCHAR    = 4'd6,
		KIND_LABELEND = 4'd7,
		KIND_QTYPE    = 4'd8,
		KIND_QCLASS   = 4'd9,
		KIND_ATYPE    = 4'd10,
		KIND_ACLASS   = 4'd11,
		KIND_TTL      = 4'd12,
		KIND_RDATA    = 4'd13
	} kind_t;

	// Byte offsets inside the fixed-size parts of the message.
	localparam logic [15:0] HDR_ID_LO    = 16'd1;
	localparam logic [15:0] HDR_FLAGS_LO = 16'd3;
	localparam logic [15:0] HDR_QD_LO    = 16'd5;
	localparam logic [15:0] HDR_AN_LO    = 16'd7;
	localparam logic [15:0] HDR_NS_LO    = 16'd9;
	localparam logic [15:0] HDR_AR_LO    = 16'd11;
	localparam logic [15:0] HDR_LAST     = 16'd11;
	localparam logic [15:0] QF_TYPE_LO   = 16'd1;
	localparam logic [15:0] QF_CLASS_LO  = 16'd3;
	localparam logic [15:0] QF_LAST      = 16'd3;
	localparam logic [15:0] AF_TYPE_LO   = 16'd3;
	localparam logic [15:0] AF_CLASS_LO  = 16'd5;
	localparam logic [15:0] AF_TTL_LO    = 16'd9;
	localparam logic [15:0] AF_LAST      = 16'd11;

	// One parsed item before value formatting; acc holds the raw shifted bytes.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] acc;
		logic [15:0] rpos;
		logic [15:0] rec;
		logic        done;
		logic        err;
	} evt_t;

endpackage

[rtl/dnsp_front.sv]
// Front end of the DNS response field parser: tracks the parse phase per byte
// and produces at most one event per accepted byte.
// Depends on dnsp_pkg.
module dnsp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_message,
	output logic              evt_valid,
	output dnsp_pkg::evt_t    evt
);

	dnsp_pkg::phase_t phase_q, phase_d, phase_adv;
	logic [15:0] bp_q, bp_d;
	logic [31:0] acc_q, acc_d, acc_shift;
	logic [7:0]  lab_q, lab_d;
	logic [15:0] ql_q, ql_d;
	logic [15:0] al_q, al_d;
	logic [15:0] rdr_q, rdr_d;
	logic [15:0] rec_q, rec_d;

	assign acc_shift = {acc_q[23:0], data_byte};

	// Next state.
	always_comb begin
		phase_adv = phase_q;
		bp_d      = bp_q;
		acc_d     = acc_q;
		lab_d     = lab_q;
		ql_d      = ql_q;
		al_d      = al_q;
		rdr_d     = rdr_q;
		rec_d     = rec_q;
		if (accept && phase_q != dnsp_pkg::PH_DONE) begin
			acc_d = acc_shift;
			unique case (phase_q)
				dnsp_pkg::PH_HEADER: begin
					if (bp_q == dnsp_pkg::HDR_QD_LO) ql_d = acc_shift[15:0];
					if (bp_q == dnsp_pkg::HDR_AN_LO) al_d = acc_shift[15:0];
					bp_d = bp_q + 16'd1;
					if (bp_q == dnsp_pkg::HDR_LAST) begin
						bp_d  = '0;
						rec_d = '0;
						if (ql_q != 16'd0)
							phase_adv = dnsp_pkg::PH_QLEN;
						else
							phase_adv = (al_q != 16'd0) ? dnsp_pkg::PH_AFIXED
							                            : dnsp_pkg::PH_DONE;
					end
				end
				dnsp_pkg::PH_QLEN: begin
					if (data_byte == 8'd0) begin
						phase_adv = dnsp_pkg::PH_QFIXED;
						bp_d      = '0;
					end else begin
						lab_d     = data_byte;
						phase_adv = dnsp_pkg::PH_QCHAR;
					end
				end
				dnsp_pkg::PH_QCHAR: begin
					lab_d = lab_q - 8'd1;
					if (lab_q == 8'd1) phase_adv = dnsp_pkg::PH_QLEN;
				end
				dnsp_pkg::PH_QFIXED: begin
					bp_d = bp_q + 16'd1;
					if (bp_q == dnsp_pkg::QF_LAST) begin
						bp_d  = '0;
						ql_d  = ql_q - 16'd1;
						rec_d = rec_q + 16'd1;
						if (ql_q != 16'd1) begin
							phase_adv = dnsp_pkg::PH_QLEN;
						end else begin
							// Last question done: the answer index restarts at zero.
							rec_d     = '0;
							phase_adv = (al_q != 16'd0) ? dnsp_pkg::PH_AFIXED
							                            : dnsp_pkg::PH_DONE;
						end
					end
				end
				dnsp_pkg::PH_AFIXED: begin
					bp_d = bp_q + 16'd1;
					if (bp_q == dnsp_pkg::AF_LAST) begin
						rdr_d = acc_shift[15:0];
						bp_d  = '0;
						if (acc_shift[15:0] == 16'd0) begin
							al_d      = al_q - 16'd1;
							rec_d     = rec_q + 16'd1;
							phase_adv = (al_q != 16'd1) ? dnsp_pkg::PH_AFIXED
							                            : dnsp_pkg::PH_DONE;
						end else begin
							phase_adv = dnsp_pkg::PH_RDATA;
						end
					end
				end
				dnsp_pkg::PH_RDATA: begin
					bp_d  = bp_q + 16'd1;
					rdr_d = rdr_q - 16'd1;
					if (rdr_q == 16'd1) begin
						al_d      = al_q - 16'd1;
						rec_d     = rec_q + 16'd1;
						bp_d      = '0;
						phase_adv = (al_q != 16'd1) ? dnsp_pkg::PH_AFIXED
						                            : dnsp_pkg::PH_DONE;
					end
				end
				default: begin
					phase_adv = dnsp_pkg::PH_HEADER;
					bp_d      = '0;
					acc_d     = '0;
					lab_d     = '0;
					ql_d      = '0;
					al_d      = '0;
					rdr_d     = '0;
					rec_d     = '0;
				end
			endcase
		end
		phase_d = phase_adv;
		// The final byte of a message always returns the parser to its reset state.
		if (accept && end_of_message) begin
			phase_d = dnsp_pkg::PH_HEADER;
			bp_d    = '0;
			acc_d   = '0;
			lab_d   = '0;
			ql_d    = '0;
			al_d    = '0;
			rdr_d   = '0;
			rec_d   = '0;
		end
	end

	// Event output.
	always_comb begin
		logic have;
		have      = 1'b0;
		evt.kind  = dnsp_pkg::KIND_ID;
		evt.acc   = acc_shift;
		evt.rpos  = '0;
		evt.rec   = rec_q;
		evt.done  = 1'b0;
		evt.err   = 1'b0;
		unique case (phase_q)
			dnsp_pkg::PH_HEADER: begin
				have = 1'b1;
				case (bp_q)
					dnsp_pkg::HDR_ID_LO:    evt.kind = dnsp_pkg::KIND_ID;
					dnsp_pkg::HDR_FLAGS_LO: evt.kind = dnsp_pkg::KIND_FLAGS;
					dnsp_pkg::HDR_QD_LO:    evt.kind = dnsp_pkg::KIND_QDCOUNT;
					dnsp_pkg::HDR_AN_LO:    evt.kind = dnsp_pkg::KIND_ANCOUNT;
					dnsp_pkg::HDR_NS_LO:    evt.kind = dnsp_pkg::KIND_NSCOUNT;
					dnsp_pkg::HDR_AR_LO:    evt.kind = dnsp_pkg::KIND_ARCOUNT;
					default:                have = 1'b0;
				endcase
			end
			dnsp_pkg::PH_QLEN: begin
				have     = 1'b1;
				evt.kind = dnsp_pkg::KIND_LABELEND;
			end
			dnsp_pkg::PH_QCHAR: begin
				have     = 1'b1;
				evt.kind = dnsp_pkg::KIND_QCHAR;
			end
			dnsp_pkg::PH_QFIXED: begin
				have = 1'b1;
				case (bp_q)
					dnsp_pkg::QF_TYPE_LO:  evt.kind = dnsp_pkg::KIND_QTYPE;
					dnsp_pkg::QF_CLASS_LO: evt.kind = dnsp_pkg::KIND_QCLASS;
					default:               have = 1'b0;
				endcase
			end
			dnsp_pkg::PH_AFIXED: begin
				have = 1'b1;
				case (bp_q)
					dnsp_pkg::AF_TYPE_LO:  evt.kind = dnsp_pkg::KIND_ATYPE;
					dnsp_pkg::AF_CLASS_LO: evt.kind = dnsp_pkg::KIND_ACLASS;
					dnsp_pkg::AF_TTL_LO:   evt.kind = dnsp_pkg::KIND_TTL;
					default:               have = 1'b0;
				endcase
			end
			dnsp_pkg::PH_RDATA: begin
				have     = 1'b1;
				evt.kind = dnsp_pkg::KIND_RDATA;
				evt.rpos = bp_q;
			end
			dnsp_pkg::PH_DONE: have = 1'b0;
			default:           have = 1'b0;
		endcase
		evt.done = (phase_q != dnsp_pkg::PH_DONE) && (phase_adv == dnsp_pkg::PH_DONE);
		evt.err  = end_of_message && (phase_q != dnsp_pkg::PH_DONE)
		           && (phase_adv != dnsp_pkg::PH_DONE);
		// A byte that only finishes or aborts the message reports status with zero fields.
		if (!have && (evt.done || evt.err)) begin
			have     = 1'b1;
			evt.kind = dnsp_pkg::KIND_ID;
			evt.acc  = '0;
			evt.rpos = '0;
			evt.rec  = '0;
		end
		evt_valid = accept && (phase_q != dnsp_pkg::PH_DONE) && have;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dnsp_pkg::PH_HEADER;
			bp_q    <= '0;
			acc_q   <= '0;
			lab_q   <= '0;
			ql_q    <= '0;
			al_q    <= '0;
			rdr_q   <= '0;
			rec_q   <= '0;
		end else begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			acc_q   <= acc_d;
			lab_q   <= lab_d;
			ql_q    <= ql_d;
			al_q    <= al_d;
			rdr_q   <= rdr_d;
			rec_q   <= rec_d;
		end
	end

endmodule

[rtl/dnsp_queue.sv]
// Event queue between the parser front end and the output stage.
// Depends on dnsp_pkg.
module dnsp_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  dnsp_pkg::evt_t wr_data,
	input  logic           rd_en,
	output dnsp_pkg::evt_t rd_data,
	output logic           not_empty,
	output logic           full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	dnsp_pkg::evt_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr, do_rd;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

[rtl/dnsp_back.sv]
// Output stage of the DNS response field parser: formats each queued event
// into its item value and holds it in the result register until popped.
// Depends on dnsp_pkg.
module dnsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_avail,
	input  dnsp_pkg::evt_t evt,
	output logic           evt_take,
	input  logic           pop,
	output logic           empty,
	output logic [3:0]     item_kind,
	output logic [31:0]    item_value,
	output logic [15:0]    rdata_position,
	output logic [15:0]    record_number,
	output logic           message_done,
	output logic           parse_error
);

	logic        valid_q;
	logic [31:0] value_fmt;

	assign empty    = !valid_q;
	assign evt_take = evt_avail && (!valid_q || pop);

	always_comb begin
		case (evt.kind) inside
			dnsp_pkg::KIND_FLAGS:
				value_fmt = {27'd0, evt.acc[15], evt.acc[10], evt.acc[9], evt.acc[8],
				             evt.acc[7]};
			dnsp_pkg::KIND_TTL:
				value_fmt = evt.acc;
			dnsp_pkg::KIND_QCHAR, dnsp_pkg::KIND_LABELEND, dnsp_pkg::KIND_RDATA:
				value_fmt = {24'd0, evt.acc[7:0]};
			default:
				value_fmt = {16'd0, evt.acc[15:0]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (evt_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			item_kind      <= evt.kind;
			item_value     <= value_fmt;
			rdata_position <= evt.rpos;
			record_number  <= evt.rec;
			message_done   <= evt.done;
			parse_error    <= evt.err;
		end
	end

endmodule

[rtl/dns_response_field_parser_top.sv]
// Top level of the DNS response field parser: front end, event queue and output stage.
// Depends on dnsp_pkg, dnsp_front, dnsp_queue and dnsp_back.
//
// The parser takes one message byte per clock while full is low; each byte's phase
// update finishes in the cycle it is accepted, so a steady stream runs at one byte
// per cycle. A byte that yields an item writes one entry into a QUEUE_DEPTH-entry
// event queue; the output register loads from that queue when it is empty or being
// popped, so a result passes the queue and the output register on its way out. full
// rises only when the queue is full because pop has been held low.
module dns_response_field_parser_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  item_kind,
	output logic [31:0] item_value,
	output logic [15:0] rdata_position,
	output logic [15:0] record_number,
	output logic        message_done,
	output logic        parse_error
);

	logic           accept;
	logic           evt_valid;
	dnsp_pkg::evt_t evt_in, evt_out;
	logic           evt_avail, evt_take;

	assign accept = push && !full;

	dnsp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.evt_valid      (evt_valid),
		.evt            (evt_in)
	);

	dnsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (evt_valid),
		.wr_data   (evt_in),
		.rd_en     (evt_take),
		.rd_data   (evt_out),
		.not_empty (evt_avail),
		.full      (full)
	);

	dnsp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt_avail      (evt_avail),
		.evt            (evt_out),
		.evt_take       (evt_take),
		.pop            (pop),
		.empty          (empty),
		.item_kind      (item_kind),
		.item_value     (item_value),
		.rdata_position (rdata_position),
		.record_number  (record_number),
		.message_done   (message_done),
		.parse_error    (parse_error)
	);

endmodule

[rtl/dnsp_checker.sv]
// Port-level checks for the DNS response field parser, bound to the top level.
// Depends on dnsp_pkg and dns_response_field_parser_top.
module dnsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pop,
	input logic        empty,
	input logic [3:0]  item_kind,
	input logic [31:0] item_value,
	input logic [15:0] rdata_position,
	input logic        message_done,
	input logic        parse_error
);

	// A finished message and an aborted one are never reported on the same beat.
	a_done_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(message_done && parse_error))
		else $error("message_done and parse_error both set");

	// Only data bytes carry an offset.
	a_rpos_rdata_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && item_kind != dnsp_pkg::KIND_RDATA) |-> rdata_position == 16'd0)
		else $error("rdata_position set on a non-rdata beat");

	// The flags beat packs five bits.
	a_flags_width: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && item_kind == dnsp_pkg::KIND_FLAGS) |-> item_value[31:5] == 27'd0)
		else $error("flags value wider than five bits");

	// A beat that is not popped stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(item_value) && $stable(item_kind)))
		else $error("waiting beat changed before pop");

endmodule

bind dns_response_field_parser_top dnsp_checker u_dnsp_checker (.*);
